>>> design/manhattan_nearest_site_area_counter_assert.svh
// Assertion macros used by the top-level RTL.
`ifndef MANHATTAN_NEAREST_SITE_AREA_COUNTER_ASSERT_SVH
`define MANHATTAN_NEAREST_SITE_AREA_COUNTER_ASSERT_SVH

// same-cycle implication
`define MNSAC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MNSAC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/mnsac_pkg.sv
`timescale 1ns / 1ps

package mnsac_pkg;

    localparam int MAX_SITES_DEF  = 64;
    localparam int COORD_BITS_DEF = 10;

    localparam int ACT_W  = 2;
    localparam int POS_W  = 10;
    localparam int SLOT_W = 6;
    localparam int CFG_W  = 7;
    localparam int DIST_W = 11;
    localparam int AREA_W = 21;

    localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

    localparam logic [ACT_W-1:0] ACT_LOAD     = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CLASSIFY = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ     = 2'd2;

    typedef struct packed {
        logic              done;
        logic              found;
        logic              is_unique;
        logic [DIST_W-1:0] min_dist;
    } scan_stat_t;

    typedef struct packed {
        logic rd_en;
        logic inc_en;
    } area_cmd_t;

endpackage

>>> design/mnsac_site_mem.sv
`timescale 1ns / 1ps

module mnsac_site_mem #(
    parameter int MAX_SITES  = mnsac_pkg::MAX_SITES_DEF,
    parameter int COORD_BITS = mnsac_pkg::COORD_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [$clog2(MAX_SITES)-1:0]           wr_addr,
    input  logic [2*((COORD_BITS < mnsac_pkg::POS_W) ?
                     COORD_BITS : mnsac_pkg::POS_W)-1:0] wr_data,
    input  logic                                   rd_en,
    input  logic [$clog2(MAX_SITES)-1:0]           rd_addr,
    output logic [2*((COORD_BITS < mnsac_pkg::POS_W) ?
                     COORD_BITS : mnsac_pkg::POS_W)-1:0] rd_data
);
    import mnsac_pkg::*;

    localparam int CW = (COORD_BITS < POS_W) ? COORD_BITS : POS_W;

    // {x, y} per site
    logic [2*CW-1:0] mem [MAX_SITES];
    logic [2*CW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/mnsac_area_mem.sv
`timescale 1ns / 1ps

module mnsac_area_mem #(
    parameter int MAX_SITES = mnsac_pkg::MAX_SITES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mnsac_pkg::area_cmd_t            cmd,
    input  logic [$clog2(MAX_SITES)-1:0]    rd_addr,
    output logic [mnsac_pkg::AREA_W-1:0]    rd_data,
    output logic                            clearing
);
    import mnsac_pkg::*;

    localparam int AW = $clog2(MAX_SITES);

    logic [AREA_W-1:0] mem [MAX_SITES];
    logic [AREA_W-1:0] rd_data_reg;
    logic [AW-1:0]     addr_reg;
    logic [AW-1:0]     clr_cnt_reg;
    logic              clearing_reg;

    // clear sweep after reset, then saturating increment of the last entry read
    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            mem[clr_cnt_reg] <= '0;
        end else if (cmd.inc_en && rd_data_reg != AREA_MAX) begin
            mem[addr_reg] <= rd_data_reg + 1'b1;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
            addr_reg    <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clearing_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == AW'(MAX_SITES - 1)) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

endmodule

>>> design/mnsac_scan.sv
`timescale 1ns / 1ps

module mnsac_scan #(
    parameter int MAX_SITES  = mnsac_pkg::MAX_SITES_DEF,
    parameter int COORD_BITS = mnsac_pkg::COORD_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic [$clog2(MAX_SITES+1)-1:0]         n,
    input  logic [((COORD_BITS < mnsac_pkg::POS_W) ?
                   COORD_BITS : mnsac_pkg::POS_W)-1:0] px,
    input  logic [((COORD_BITS < mnsac_pkg::POS_W) ?
                   COORD_BITS : mnsac_pkg::POS_W)-1:0] py,
    output logic                                   rd_en,
    output logic [$clog2(MAX_SITES)-1:0]           rd_addr,
    input  logic [2*((COORD_BITS < mnsac_pkg::POS_W) ?
                     COORD_BITS : mnsac_pkg::POS_W)-1:0] rd_data,
    output logic [$clog2(MAX_SITES)-1:0]           best_idx,
    output mnsac_pkg::scan_stat_t                  stat
);
    import mnsac_pkg::*;

    localparam int CW    = (COORD_BITS < POS_W) ? COORD_BITS : POS_W;
    localparam int AW    = $clog2(MAX_SITES);
    localparam int CNT_W = $clog2(MAX_SITES + 1);

    function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    logic             busy_reg, issuing_reg;
    logic [CNT_W-1:0] issue_reg, n_reg;
    logic [CNT_W-1:0] issue_inc;
    logic [CW-1:0]    px_reg, py_reg;
    logic             v1_reg, v2_reg;
    logic [AW-1:0]    idx1_reg, idx2_reg;
    logic [CW:0]      dist_reg, best_reg;
    logic [AW-1:0]    best_idx_reg;
    logic             found_reg, multi_reg;
    logic             done;
    logic [CW:0]      dist_calc;

    assign issue_inc = issue_reg + 1'b1;
    assign rd_en     = issuing_reg;
    assign rd_addr   = issue_reg[AW-1:0];
    assign done      = busy_reg && !issuing_reg && !v1_reg && !v2_reg;
    assign dist_calc = {1'b0, abs_diff(rd_data[2*CW-1:CW], px_reg)}
                     + {1'b0, abs_diff(rd_data[CW-1:0], py_reg)};

    // issue -> memory read -> distance -> compare
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            issuing_reg <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            found_reg   <= 1'b0;
            multi_reg   <= 1'b0;
        end else begin
            v1_reg <= rd_en;
            v2_reg <= v1_reg;
            if (start) begin
                busy_reg    <= 1'b1;
                issuing_reg <= (n != '0);
                found_reg   <= 1'b0;
                multi_reg   <= 1'b0;
            end else begin
                if (done) begin
                    busy_reg <= 1'b0;
                end
                if (issuing_reg && issue_inc == n_reg) begin
                    issuing_reg <= 1'b0;
                end
                if (v2_reg) begin
                    if (!found_reg || dist_reg < best_reg) begin
                        found_reg <= 1'b1;
                        multi_reg <= 1'b0;
                    end else if (dist_reg == best_reg) begin
                        multi_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx1_reg <= rd_addr;
        idx2_reg <= idx1_reg;
        dist_reg <= dist_calc;
        if (start) begin
            n_reg        <= n;
            px_reg       <= px;
            py_reg       <= py;
            issue_reg    <= '0;
            best_reg     <= '0;
            best_idx_reg <= '0;
        end else begin
            if (issuing_reg) begin
                issue_reg <= issue_inc;
            end
            if (v2_reg && (!found_reg || dist_reg < best_reg)) begin
                best_reg     <= dist_reg;
                best_idx_reg <= idx2_reg;
            end
        end
    end

    assign best_idx       = best_idx_reg;
    assign stat.done      = done;
    assign stat.found     = found_reg;
    assign stat.is_unique = found_reg && !multi_reg;
    assign stat.min_dist  = DIST_W'(best_reg);

endmodule

>>> design/manhattan_nearest_site_area_counter.sv
// Nearest-site labeler with per-site area counters. Load items write a site's
// coordinates into the site memory; classify items compare one cell against
// sites 0 .. sites_in_use-1 (capped at MAX_SITES) by Manhattan distance and
// return the lowest-index nearest site, its distance and a uniqueness flag; a
// unique winner's area count is bumped (saturating). Read items return a
// site's area count. One item is in flight at a time. A classify's scan reads one
// site per cycle from the single read port of the site memory. Results sit in an
// output register, so the next item is taken while a result waits. After reset
// the area memory is cleared one entry per cycle, and no item is accepted
// meanwhile; configuration writes are taken at any time.
`timescale 1ns / 1ps

`include "manhattan_nearest_site_area_counter_assert.svh"

module manhattan_nearest_site_area_counter #(
    parameter int MAX_SITES  = mnsac_pkg::MAX_SITES_DEF,
    parameter int COORD_BITS = mnsac_pkg::COORD_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mnsac_pkg::CFG_W-1:0]     cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [mnsac_pkg::ACT_W-1:0]     s_action,
    input  logic [mnsac_pkg::POS_W-1:0]     s_pos_x,
    input  logic [mnsac_pkg::POS_W-1:0]     s_pos_y,
    input  logic [mnsac_pkg::SLOT_W-1:0]    s_site_slot,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [mnsac_pkg::SLOT_W-1:0]    m_nearest_slot,
    output logic                            m_is_unique,
    output logic [mnsac_pkg::DIST_W-1:0]    m_best_distance,
    output logic [mnsac_pkg::AREA_W-1:0]    m_area_value
);
    import mnsac_pkg::*;

    localparam int CW    = (COORD_BITS < POS_W) ? COORD_BITS : POS_W;
    localparam int AW    = $clog2(MAX_SITES);
    localparam int CNT_W = $clog2(MAX_SITES + 1);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SCAN    = 3'd1;
    localparam logic [2:0] ST_AREA_WR = 3'd2;
    localparam logic [2:0] ST_READ    = 3'd3;
    localparam logic [2:0] ST_FIN     = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CFG_W-1:0]  sites_in_use_reg;
    logic              m_valid_reg, m_valid_next;
    logic [SLOT_W-1:0] m_slot_reg, m_slot_next;
    logic              m_unique_reg, m_unique_next;
    logic [DIST_W-1:0] m_dist_reg, m_dist_next;
    logic [AREA_W-1:0] m_area_reg, m_area_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic              res_unique_reg, res_unique_next;
    logic [DIST_W-1:0] res_dist_reg, res_dist_next;
    logic [AREA_W-1:0] res_area_reg, res_area_next;

    logic              accept;
    logic              slot_ok;
    logic [AW-1:0]     slot_addr;
    logic [CNT_W-1:0]  n_use;
    logic              site_wr_en;
    logic              scan_start;
    logic              site_rd_en;
    logic [AW-1:0]     site_rd_addr;
    logic [2*CW-1:0]   site_rd_data;
    logic [AW-1:0]     best_idx;
    scan_stat_t        scan_stat;
    area_cmd_t         area_cmd;
    logic [AW-1:0]     area_rd_addr;
    logic [AREA_W-1:0] area_rd_data;
    logic              clearing;

    assign cfg_ready  = 1'b1;
    assign s_ready    = (state_reg == ST_IDLE) && !clearing;
    assign accept     = s_valid && s_ready;
    assign slot_ok    = 32'(s_site_slot) < MAX_SITES;
    assign slot_addr  = AW'(s_site_slot);
    assign n_use      = (32'(sites_in_use_reg) > MAX_SITES) ? CNT_W'(MAX_SITES)
                                                             : CNT_W'(sites_in_use_reg);
    assign site_wr_en = accept && s_action == ACT_LOAD && slot_ok;
    assign scan_start = accept && s_action == ACT_CLASSIFY;

    assign area_cmd.rd_en  = (accept && s_action == ACT_READ && slot_ok)
                          || (state_reg == ST_SCAN && scan_stat.done && scan_stat.is_unique);
    assign area_cmd.inc_en = (state_reg == ST_AREA_WR);
    assign area_rd_addr    = (state_reg == ST_IDLE) ? slot_addr : best_idx;

    mnsac_site_mem #(
        .MAX_SITES  (MAX_SITES),
        .COORD_BITS (COORD_BITS)
    ) u_site_mem (
        .aclk    (aclk),
        .wr_en   (site_wr_en),
        .wr_addr (slot_addr),
        .wr_data ({s_pos_x[CW-1:0], s_pos_y[CW-1:0]}),
        .rd_en   (site_rd_en),
        .rd_addr (site_rd_addr),
        .rd_data (site_rd_data)
    );

    mnsac_scan #(
        .MAX_SITES  (MAX_SITES),
        .COORD_BITS (COORD_BITS)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (scan_start),
        .n        (n_use),
        .px       (s_pos_x[CW-1:0]),
        .py       (s_pos_y[CW-1:0]),
        .rd_en    (site_rd_en),
        .rd_addr  (site_rd_addr),
        .rd_data  (site_rd_data),
        .best_idx (best_idx),
        .stat     (scan_stat)
    );

    mnsac_area_mem #(
        .MAX_SITES (MAX_SITES)
    ) u_area_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (area_cmd),
        .rd_addr  (area_rd_addr),
        .rd_data  (area_rd_data),
        .clearing (clearing)
    );

    always_comb begin
        state_next      = state_reg;
        res_slot_next   = res_slot_reg;
        res_unique_next = res_unique_reg;
        res_dist_next   = res_dist_reg;
        res_area_next   = res_area_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_slot_next     = m_slot_reg;
        m_unique_next   = m_unique_reg;
        m_dist_next     = m_dist_reg;
        m_area_next     = m_area_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_slot_next   = '0;
                    res_unique_next = 1'b0;
                    res_dist_next   = '0;
                    res_area_next   = '0;
                    case (s_action)
                        ACT_CLASSIFY: state_next = ST_SCAN;
                        ACT_READ:     state_next = slot_ok ? ST_READ : ST_FIN;
                        default:      state_next = ST_FIN;
                    endcase
                end
            end
            ST_SCAN: begin
                if (scan_stat.done) begin
                    res_slot_next   = SLOT_W'(best_idx);
                    res_unique_next = scan_stat.is_unique;
                    res_dist_next   = scan_stat.min_dist;
                    state_next      = scan_stat.is_unique ? ST_AREA_WR : ST_FIN;
                end
            end
            ST_AREA_WR: begin
                state_next = ST_FIN;
            end
            ST_READ: begin
                res_area_next = area_rd_data;
                state_next    = ST_FIN;
            end
            ST_FIN: begin
                // output register free or draining this cycle
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_slot_next   = res_slot_reg;
                    m_unique_next = res_unique_reg;
                    m_dist_next   = res_dist_reg;
                    m_area_next   = res_area_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            m_valid_reg      <= 1'b0;
            sites_in_use_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                sites_in_use_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_slot_reg   <= res_slot_next;
        res_unique_reg <= res_unique_next;
        res_dist_reg   <= res_dist_next;
        res_area_reg   <= res_area_next;
        m_slot_reg     <= m_slot_next;
        m_unique_reg   <= m_unique_next;
        m_dist_reg     <= m_dist_next;
        m_area_reg     <= m_area_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_nearest_slot  = m_slot_reg;
    assign m_is_unique     = m_unique_reg;
    assign m_best_distance = m_dist_reg;
    assign m_area_value    = m_area_reg;

    `MNSAC_ASSERT_IMP(a_scan_done_in_scan, aclk, aresetn, scan_stat.done,
        state_reg == ST_SCAN, "scan finished outside of a classify")
    `MNSAC_ASSERT_IMP(a_inc_after_unique, aclk, aresetn, state_reg == ST_AREA_WR,
        $past(scan_stat.done && scan_stat.is_unique), "area bump without unique winner")
    `MNSAC_ASSERT_NXT(a_accept_leaves_idle, aclk, aresetn, accept,
        state_reg != ST_IDLE, "accepted item did not start processing")
    `MNSAC_ASSERT_IMP(a_no_read_while_clearing, aclk, aresetn, area_cmd.rd_en,
        !clearing, "area memory read during clear sweep")

endmodule

>>> tb/sv/mnsac_cell_checker.sv
`timescale 1ns / 1ps

module mnsac_cell_checker #(
    parameter int MAX_SITES = mnsac_pkg::MAX_SITES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [mnsac_pkg::CFG_W-1:0]  cfg_data,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [mnsac_pkg::ACT_W-1:0]  s_action,
    input  logic [mnsac_pkg::POS_W-1:0]  s_pos_x,
    input  logic [mnsac_pkg::POS_W-1:0]  s_pos_y,
    input  logic [mnsac_pkg::SLOT_W-1:0] s_site_slot,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [mnsac_pkg::SLOT_W-1:0] m_nearest_slot,
    input  logic                         m_is_unique,
    input  logic [mnsac_pkg::DIST_W-1:0] m_best_distance,
    input  logic [mnsac_pkg::AREA_W-1:0] m_area_value,
    output int                           mismatches,
    output int                           outstanding,
    output int                           unique_wins,
    output int                           ties_seen
);
    import mnsac_pkg::*;

    typedef struct packed {
        logic [SLOT_W-1:0] nearest_slot;
        logic              is_unique;
        logic [DIST_W-1:0] best_distance;
        logic [AREA_W-1:0] area_value;
    } cell_result_t;

    // site coordinates are never reset; stimulus loads before it classifies
    logic [POS_W-1:0]  site_x [MAX_SITES];
    logic [POS_W-1:0]  site_y [MAX_SITES];
    logic [AREA_W-1:0] area_count [MAX_SITES];
    int                sites_used = 0;
    cell_result_t      cell_results_q [$];

    int fail_count = 0;
    int unique_count = 0;
    int tie_count = 0;
    int queued = 0;

    assign mismatches  = fail_count;
    assign outstanding = queued;
    assign unique_wins = unique_count;
    assign ties_seen   = tie_count;

    function automatic cell_result_t label_cell(input logic [ACT_W-1:0]  act,
                                                input logic [POS_W-1:0]  x,
                                                input logic [POS_W-1:0]  y,
                                                input logic [SLOT_W-1:0] slot);
        cell_result_t r;
        int n;
        int dx;
        int dy;
        int best;
        int best_idx;
        int ties;
        r = '0;
        case (act)
            ACT_LOAD: begin
                if (slot < MAX_SITES) begin
                    site_x[slot] = x;
                    site_y[slot] = y;
                end
            end
            ACT_CLASSIFY: begin
                n = (sites_used > MAX_SITES) ? MAX_SITES : sites_used;
                best = 0;
                best_idx = 0;
                ties = 0;
                for (int i = 0; i < n; i++) begin
                    dx = int'(site_x[i]) - int'(x);
                    dy = int'(site_y[i]) - int'(y);
                    if (dx < 0) dx = -dx;
                    if (dy < 0) dy = -dy;
                    if (ties == 0 || dx + dy < best) begin
                        best = dx + dy;
                        best_idx = i;
                        ties = 1;
                    end else if (dx + dy == best) begin
                        ties++;
                    end
                end
                if (ties != 0) begin
                    r.nearest_slot  = best_idx[SLOT_W-1:0];
                    r.is_unique     = (ties == 1);
                    r.best_distance = best[DIST_W-1:0];
                    if (ties == 1 && area_count[best_idx] != AREA_MAX)
                        area_count[best_idx] = area_count[best_idx] + 1'b1;
                end
            end
            ACT_READ: begin
                if (slot < MAX_SITES)
                    r.area_value = area_count[slot];
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void compare_field(input string field, input int want, input int got);
        if (want != got) begin
            fail_count++;
            $error("%s: expected %0d, got %0d", field, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        cell_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < MAX_SITES; i++)
                area_count[i] = '0;
            sites_used = 0;
            cell_results_q.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                sites_used = int'(cfg_data);
            // the result register holds an older item, so compare before predicting
            if (m_valid && m_ready) begin
                if (cell_results_q.size() == 0) begin
                    fail_count++;
                    $error("result transfer with nothing expected (slot %0d, dist %0d)",
                           m_nearest_slot, m_best_distance);
                end else begin
                    want = cell_results_q.pop_front();
                    compare_field("nearest_slot", int'(want.nearest_slot),
                                  int'(m_nearest_slot));
                    compare_field("is_unique", int'(want.is_unique), int'(m_is_unique));
                    compare_field("best_distance", int'(want.best_distance),
                                  int'(m_best_distance));
                    compare_field("area_value", int'(want.area_value), int'(m_area_value));
                end
            end
            if (s_valid && s_ready) begin
                want = label_cell(s_action, s_pos_x, s_pos_y, s_site_slot);
                cell_results_q = {cell_results_q, want};
                if (s_action == ACT_CLASSIFY && want.is_unique)
                    unique_count++;
                else if (s_action == ACT_CLASSIFY && sites_used != 0)
                    tie_count++;
            end
        end
        queued = cell_results_q.size();
    end

endmodule

>>> tb/sv/manhattan_nearest_site_area_counter_tb.sv
`timescale 1ns / 1ps

module manhattan_nearest_site_area_counter_tb;
    import mnsac_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int STALL_LIMIT     = 4000;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 80;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_valid   = 1'b0;
    logic [CFG_W-1:0]  cfg_data    = '0;
    logic              s_valid     = 1'b0;
    logic [ACT_W-1:0]  s_action    = '0;
    logic [POS_W-1:0]  s_pos_x     = '0;
    logic [POS_W-1:0]  s_pos_y     = '0;
    logic [SLOT_W-1:0] s_site_slot = '0;
    logic              m_ready     = 1'b0;

    logic              cfg_ready;
    logic              s_ready;
    logic              m_valid;
    logic [SLOT_W-1:0] m_nearest_slot;
    logic              m_is_unique;
    logic [DIST_W-1:0] m_best_distance;
    logic [AREA_W-1:0] m_area_value;

    int mismatches;
    int outstanding;
    int unique_wins;
    int ties_seen;

    int tx_idle_pct = 16;
    int rx_idle_pct = 85;
    bit hold_request = 1'b0;
    int quiet_cycles = 0;
    int n_load = 0;
    int n_classify = 0;
    int n_read = 0;
    int n_unused = 0;
    int n_settings = 0;

    always #1 aclk = ~aclk;

    manhattan_nearest_site_area_counter dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_pos_x         (s_pos_x),
        .s_pos_y         (s_pos_y),
        .s_site_slot     (s_site_slot),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_nearest_slot  (m_nearest_slot),
        .m_is_unique     (m_is_unique),
        .m_best_distance (m_best_distance),
        .m_area_value    (m_area_value)
    );

    mnsac_cell_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_pos_x         (s_pos_x),
        .s_pos_y         (s_pos_y),
        .s_site_slot     (s_site_slot),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_nearest_slot  (m_nearest_slot),
        .m_is_unique     (m_is_unique),
        .m_best_distance (m_best_distance),
        .m_area_value    (m_area_value),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .unique_wins     (unique_wins),
        .ties_seen       (ties_seen)
    );

    // result side: random back-pressure, plus one long hold on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("no transfer for %0d cycles", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [POS_W-1:0] pick_coord();
        int r;
        r = $urandom_range(99);
        // corners and a small cluster make duplicate sites and ties common
        if (r < 10) return '0;
        if (r < 20) return '1;
        if (r < 50) return POS_W'($urandom_range(31));
        return POS_W'($urandom);
    endfunction

    task automatic offer_item(input logic [ACT_W-1:0]  act,
                              input logic [POS_W-1:0]  x,
                              input logic [POS_W-1:0]  y,
                              input logic [SLOT_W-1:0] slot);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_action    <= act;
        s_pos_x     <= x;
        s_pos_y     <= y;
        s_site_slot <= slot;
        do @(posedge aclk); while (!s_ready);
        case (act)
            ACT_LOAD:     n_load++;
            ACT_CLASSIFY: n_classify++;
            ACT_READ:     n_read++;
            default:      n_unused++;
        endcase
    endtask

    task automatic write_setting(input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    initial begin
        logic [CFG_W-1:0] phase_setting [6];
        int pick;
        phase_setting[0] = 7'd127;
        phase_setting[1] = 7'd0;
        phase_setting[2] = 7'd64;
        phase_setting[3] = 7'd65;
        phase_setting[4] = CFG_W'($urandom_range(2, 63));
        phase_setting[5] = 7'd1;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // no site in use: classify gives zeros, reads see cleared counters
        write_setting(7'd0);
        offer_item(ACT_CLASSIFY, 10'd5, 10'd7, 6'd0);
        offer_item(ACT_READ, 10'd0, 10'd0, 6'd0);
        offer_item(ACT_UNUSED, 10'd321, 10'd654, 6'd21);
        offer_item(ACT_LOAD, 10'd0, 10'd0, 6'd0);
        offer_item(ACT_LOAD, 10'd1023, 10'd1023, 6'd1);
        offer_item(ACT_LOAD, 10'd0, 10'd0, 6'd2);
        offer_item(ACT_LOAD, 10'd1023, 10'd0, 6'd3);
        wait_idle();

        // two opposite corners: exact hits and equidistant ties
        write_setting(7'd2);
        offer_item(ACT_CLASSIFY, 10'd0, 10'd0, 6'd0);
        offer_item(ACT_CLASSIFY, 10'd1023, 10'd1023, 6'd0);
        offer_item(ACT_CLASSIFY, 10'd0, 10'd1023, 6'd0);
        offer_item(ACT_CLASSIFY, 10'd511, 10'd512, 6'd0);
        offer_item(ACT_READ, 10'd0, 10'd0, 6'd0);
        offer_item(ACT_READ, 10'd0, 10'd0, 6'd1);
        wait_idle();

        // slots 0 and 2 share a position, so they always tie
        write_setting(7'd4);
        offer_item(ACT_CLASSIFY, 10'd0, 10'd0, 6'd0);
        offer_item(ACT_CLASSIFY, 10'd1023, 10'd0, 6'd0);
        offer_item(ACT_CLASSIFY, 10'd1023, 10'd1023, 6'd63);
        offer_item(ACT_READ, 10'd0, 10'd0, 6'd3);
        offer_item(ACT_READ, 10'd0, 10'd0, 6'd63);
        offer_item(ACT_UNUSED, 10'd1023, 10'd1023, 6'd63);

        // load every slot so any site count can be classified
        for (int slot = 0; slot < MAX_SITES_DEF; slot++)
            offer_item(ACT_LOAD, pick_coord(), pick_coord(), SLOT_W'(slot));

        // area counters saturate only after 2M unique wins, out of reach here
        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            write_setting(phase_setting[ph]);
            case (ph / 2)
                0: begin
                    tx_idle_pct = 16;
                    rx_idle_pct = 85;
                end
                1: begin
                    tx_idle_pct = 85;
                    rx_idle_pct = 16;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            if (ph == 4)
                hold_request = 1'b1;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                pick = $urandom_range(99);
                if (pick < 60)
                    offer_item(ACT_CLASSIFY, pick_coord(), pick_coord(), SLOT_W'($urandom));
                else if (pick < 78)
                    offer_item(ACT_LOAD, pick_coord(), pick_coord(), SLOT_W'($urandom));
                else if (pick < 95)
                    offer_item(ACT_READ, POS_W'($urandom), POS_W'($urandom),
                               SLOT_W'($urandom));
                else
                    offer_item(ACT_UNUSED, POS_W'($urandom), POS_W'($urandom),
                               SLOT_W'($urandom));
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d loads, %0d classifies (%0d unique, %0d tied), %0d reads, %0d unused",
                 n_load, n_classify, unique_wins, ties_seen, n_read, n_unused);
        $display("across %0d site-count writes from 0 to 127, swapped idling and a long stall",
                 n_settings);
        if (mismatches == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/mnsac_pkg.sv
design/mnsac_site_mem.sv
design/mnsac_area_mem.sv
design/mnsac_scan.sv
design/manhattan_nearest_site_area_counter.sv
tb/sv/mnsac_cell_checker.sv
tb/sv/manhattan_nearest_site_area_counter_tb.sv
